[sv/nmea_gga_fixed_offset_parser_assert.svh]
// Assertion macros for the checker file of this block.
`ifndef NMEA_GGA_FIXED_OFFSET_PARSER_ASSERT_SVH
`define NMEA_GGA_FIXED_OFFSET_PARSER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define NGGA_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NGGA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/ngga_pkg.sv]
`default_nettype none

package ngga_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [5:0] POS_MAX   = 6'd63;
    localparam logic [5:0] POS_HDR_G0 = 6'd3;
    localparam logic [5:0] POS_HDR_G1 = 6'd4;
    localparam logic [5:0] POS_HDR_A  = 6'd5;
    localparam logic [5:0] LAT_FIRST = 6'd18;
    localparam logic [5:0] LAT_LAST  = 6'd26;
    localparam logic [5:0] LAT_DIR   = 6'd28;
    localparam logic [5:0] LON_FIRST = 6'd30;
    localparam logic [5:0] LON_LAST  = 6'd39;
    localparam logic [5:0] LON_DIR   = 6'd41;
    localparam logic [5:0] SAT_TENS  = 6'd45;
    localparam logic [5:0] SAT_UNITS = 6'd46;

    localparam logic [2:0] FC_NONE      = 3'd0;
    localparam logic [2:0] FC_LAT_DIGIT = 3'd1;
    localparam logic [2:0] FC_LAT_DIR   = 3'd2;
    localparam logic [2:0] FC_LON_DIGIT = 3'd3;
    localparam logic [2:0] FC_LON_DIR   = 3'd4;
    localparam logic [2:0] FC_SAT_TENS  = 3'd5;
    localparam logic [2:0] FC_SAT_UNITS = 3'd6;

    typedef struct packed {
        logic [5:0] position;
        logic       locked;
        logic [7:0] sat_count;
        logic       fix_valid;
    } parse_state_t;

    typedef struct packed {
        logic [2:0] field_code;
        logic [3:0] char_index;
        logic [7:0] char_value;
        logic [7:0] satellite_count;
        logic       fix_valid;
        logic       in_sentence;
    } parse_result_t;

endpackage

`default_nettype wire

[sv/ngga_classify.sv]
`default_nettype none

// Works out the parser's next state and the result record for one byte.
module ngga_classify (
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  byte_error,
    input  wire ngga_pkg::parse_state_t cur_state,
    output ngga_pkg::parse_state_t     next_state,
    output ngga_pkg::parse_result_t    result
);

    logic [5:0] pos;
    logic       locked;
    logic       active;
    logic [7:0] digit;
    logic [2:0] code;
    logic [3:0] idx;
    logic [7:0] sat;
    logic       fix;

    assign digit = rx_byte - ngga_pkg::CH_ZERO;

    always_comb begin
        pos    = cur_state.position;
        locked = cur_state.locked;
        sat    = cur_state.sat_count;
        fix    = cur_state.fix_valid;
        active = 1'b0;
        code   = ngga_pkg::FC_NONE;
        idx    = 4'd0;

        if (!byte_error) begin
            if (rx_byte == ngga_pkg::CH_DOLLAR) begin
                locked = 1'b1;
                pos    = 6'd0;
                active = 1'b1;
            end else if (locked) begin
                active = 1'b1;
                if (pos != ngga_pkg::POS_MAX) begin
                    pos = pos + 6'd1;
                end
            end

            if (active) begin
                if (((pos == ngga_pkg::POS_HDR_G0 || pos == ngga_pkg::POS_HDR_G1) &&
                     rx_byte != ngga_pkg::CH_G) ||
                    (pos == ngga_pkg::POS_HDR_A && rx_byte != ngga_pkg::CH_A)) begin
                    locked = 1'b0;
                end else if (pos >= ngga_pkg::LAT_FIRST && pos <= ngga_pkg::LAT_LAST) begin
                    code = ngga_pkg::FC_LAT_DIGIT;
                    idx  = 4'(pos - ngga_pkg::LAT_FIRST);
                end else if (pos == ngga_pkg::LAT_DIR) begin
                    code = ngga_pkg::FC_LAT_DIR;
                end else if (pos >= ngga_pkg::LON_FIRST && pos <= ngga_pkg::LON_LAST) begin
                    code = ngga_pkg::FC_LON_DIGIT;
                    idx  = 4'(pos - ngga_pkg::LON_FIRST);
                end else if (pos == ngga_pkg::LON_DIR) begin
                    code = ngga_pkg::FC_LON_DIR;
                end else if (pos == ngga_pkg::SAT_TENS) begin
                    code = ngga_pkg::FC_SAT_TENS;
                    // Times ten as two shifted copies.
                    sat  = {digit[4:0], 3'b000} + {digit[6:0], 1'b0};
                end else if (pos == ngga_pkg::SAT_UNITS) begin
                    code = ngga_pkg::FC_SAT_UNITS;
                    sat  = sat + digit;
                    fix  = 1'b1;
                end
            end
        end
    end

    assign next_state.position  = pos;
    assign next_state.locked    = locked;
    assign next_state.sat_count = sat;
    assign next_state.fix_valid = fix;

    assign result.field_code      = code;
    assign result.char_index      = idx;
    assign result.char_value      = rx_byte;
    assign result.satellite_count = sat;
    assign result.fix_valid       = fix;
    assign result.in_sentence     = locked;

endmodule

`default_nettype wire

[sv/ngga_out_reg.sv]
`default_nettype none

// Result register. It refills in the same cycle in which its content is taken.
module ngga_out_reg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire ngga_pkg::parse_result_t load_data,
    input  wire logic                   take,
    output logic                        out_valid,
    output ngga_pkg::parse_result_t     out_data
);

    logic                    valid_reg;
    logic                    valid_next;
    ngga_pkg::parse_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[sv/nmea_gga_fixed_offset_parser.sv]
`default_nettype none

// NMEA GGA parser with fixed character offsets. Each stream transfer on the
// slave side carries one received serial byte with its overrun and framing
// error flags, and each such transfer yields exactly one result transfer on
// the master side, from the result register. A byte is taken in every
// cycle while the result register is empty or being emptied, so the block
// sustains one byte per clock; the only storage on the path is the result
// register. A new byte enters in the same cycle in which the previous result
// leaves, but not while that result is held back by the master side.
// A '$' starts a sentence; 'G','G','A' must follow at positions 3 to 5. The
// result names the captured field (latitude or longitude digit with its
// index, direction letters, satellite digits) and carries the running
// satellite count, the sticky fix-valid flag and the sentence lock.
module nmea_gga_fixed_offset_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,  // [0] overrun_error, [1] framing_error
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] char_index, [11:4] char_value, [19:12] satellite_count,
    // [20] fix_valid, [21] in_sentence, [23:22] zero
    output logic [23:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser   // [2:0] field_code
);

    // Parser state: position within the sentence, lock, satellite count and
    // the fix flag. It advances on every accepted slave transfer.
    ngga_pkg::parse_state_t  state_reg;
    ngga_pkg::parse_state_t  state_next;
    ngga_pkg::parse_result_t result;
    ngga_pkg::parse_result_t out_data;
    logic                    in_xfer;
    logic                    out_xfer;

    // The result register can take a new value when it is empty or when its
    // value leaves in this same cycle.
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    ngga_classify u_classify (
        .rx_byte    (s_axis_tdata),
        .byte_error (s_axis_tuser[0] || s_axis_tuser[1]),
        .cur_state  (state_reg),
        .next_state (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    ngga_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_xfer),
        .load_data (result),
        .take      (out_xfer),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data)
    );

    // Pack the result fields, highest field first.
    assign m_axis_tdata = {2'b00, out_data.in_sentence, out_data.fix_valid,
                           out_data.satellite_count, out_data.char_value,
                           out_data.char_index};
    assign m_axis_tuser = out_data.field_code;

endmodule

`default_nettype wire

[sv/ngga_checker.sv]
`default_nettype none

`include "nmea_gga_fixed_offset_parser_assert.svh"

// Port-level checks of the parser's result stream.
module ngga_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // A stalled result holds its content.
    `NGGA_ASSERT_RUN(a_stall_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser),
        "result changed while stalled")

    // Reset empties the result register.
    `NGGA_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    // A captured field is only reported while the sentence lock holds.
    `NGGA_ASSERT_RUN(a_capture_locked,
        m_axis_tvalid && m_axis_tuser != ngga_pkg::FC_NONE |-> m_axis_tdata[21],
        "capture without sentence lock")

    // The units digit sets the fix flag in the same result.
    `NGGA_ASSERT_RUN(a_units_fix,
        m_axis_tvalid && m_axis_tuser == ngga_pkg::FC_SAT_UNITS |-> m_axis_tdata[20],
        "units digit without fix flag")

    // Only latitude and longitude digits carry an index.
    `NGGA_ASSERT_RUN(a_index_zero,
        m_axis_tvalid && m_axis_tuser != ngga_pkg::FC_LAT_DIGIT
            && m_axis_tuser != ngga_pkg::FC_LON_DIGIT |-> m_axis_tdata[3:0] == 4'd0,
        "index on a non-digit field")

endmodule

bind nmea_gga_fixed_offset_parser ngga_checker u_ngga_checker (.*);

`default_nettype wire

[verif/nmea_gga_fixed_offset_parser_tb.sv]
`timescale 1ns / 100ps

module nmea_gga_fixed_offset_parser_tb;

    // Error flag combinations carried in s_axis_tuser: bit 0 is overrun,
    // bit 1 is framing.
    localparam logic [1:0] FLAG_NONE    = 2'b00;
    localparam logic [1:0] FLAG_OVERRUN = 2'b01;
    localparam logic [1:0] FLAG_FRAMING = 2'b10;
    localparam logic [1:0] FLAG_BOTH    = 2'b11;

    // Number of bytes sent in all before the random stimulus stops, and the
    // length of the long receiver hold-off.
    localparam int unsigned ITEM_TARGET  = 2000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    nmea_gga_fixed_offset_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Parser state as the testbench sees it, updated once per accepted byte.
    ngga_pkg::parse_state_t  gga_state;
    // Field reports that the parser still owes, oldest first.
    ngga_pkg::parse_result_t gga_reports_due[$];

    int unsigned mismatches;
    int unsigned parsed_bytes;
    int unsigned bytes_sent;
    int unsigned error_bytes;
    int unsigned sentences;
    int unsigned header_breaks;
    int unsigned reports_seen;
    int unsigned code_seen [0:7];

    // Idling mix of the current phase, in percent of cycles.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // The sender bumps this to ask the receiver for a long hold-off; the
    // receiver counts the stretch in its own process.
    int unsigned hold_requests;

    // One row of the directed table. When has_literal is set, the expected
    // report is typed in the row; otherwise it comes from the predictor.
    typedef struct {
        logic [7:0]  rx;
        logic [1:0]  flags;
        int unsigned repeats;
        bit          has_literal;
        logic [2:0]  code;
        logic [3:0]  index;
        logic [7:0]  sats;
        logic        fix;
        logic        locked;
    } directed_row_t;

    // The directed part walks the special cases first (dropped bytes before
    // and during a sentence, ignored bytes while unlocked, a header mismatch),
    // then one complete sentence through every field, a satellite count taken
    // from non-digit bytes, a run long enough for the position to saturate,
    // and finally a header that fails on the 'A'.
    directed_row_t directed_rows [] = '{
        '{8'hFF, FLAG_NONE, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_DOLLAR, FLAG_OVERRUN, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_DOLLAR, FLAG_FRAMING, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_DOLLAR, FLAG_BOTH, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{8'h00, FLAG_NONE, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_DOLLAR, FLAG_NONE, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b1},
        '{ngga_pkg::CH_G, FLAG_NONE, 2, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{"X", FLAG_NONE, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{"5", FLAG_NONE, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_DOLLAR, FLAG_NONE, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b1},
        '{ngga_pkg::CH_G, FLAG_NONE, 3, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_G, FLAG_OVERRUN, 1, 1'b1, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b1},
        '{ngga_pkg::CH_G, FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_A, FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{",", FLAG_NONE, 12, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_ZERO, FLAG_NONE, 1, 1'b1, ngga_pkg::FC_LAT_DIGIT, 4'd0, 8'd0, 1'b0, 1'b1},
        '{"9", FLAG_NONE, 8, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{",", FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{"N", FLAG_NONE, 1, 1'b1, ngga_pkg::FC_LAT_DIR, 4'd0, 8'd0, 1'b0, 1'b1},
        '{",", FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{"7", FLAG_NONE, 10, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{",", FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{"W", FLAG_NONE, 1, 1'b1, ngga_pkg::FC_LON_DIR, 4'd0, 8'd0, 1'b0, 1'b1},
        '{",", FLAG_NONE, 3, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{8'hFF, FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{8'h00, FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{"Z", FLAG_NONE, 30, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_DOLLAR, FLAG_NONE, 1, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0},
        '{ngga_pkg::CH_G, FLAG_NONE, 5, 1'b0, ngga_pkg::FC_NONE, 4'd0, 8'd0, 1'b0, 1'b0}
    };

    // Works out the report for one accepted byte and advances the parser
    // state. A byte with either error flag leaves the state alone. A '$'
    // always restarts the position; other bytes count only while locked,
    // and the position sticks at its maximum instead of wrapping.
    function automatic ngga_pkg::parse_result_t gga_predict(input logic [7:0] rx,
                                                            input logic [1:0] flags);
        ngga_pkg::parse_result_t rep;
        logic                    on_track;
        logic [5:0]              pos;
        rep = '0;
        rep.char_value = rx;
        if (flags == FLAG_NONE) begin
            on_track = 1'b1;
            if (rx == ngga_pkg::CH_DOLLAR) begin
                gga_state.locked   = 1'b1;
                gga_state.position = '0;
            end else if (!gga_state.locked) begin
                on_track = 1'b0;
            end else if (gga_state.position < ngga_pkg::POS_MAX) begin
                gga_state.position = gga_state.position + 6'd1;
            end
            if (on_track) begin
                pos = gga_state.position;
                if (((pos == ngga_pkg::POS_HDR_G0 || pos == ngga_pkg::POS_HDR_G1)
                            && rx != ngga_pkg::CH_G)
                        || (pos == ngga_pkg::POS_HDR_A && rx != ngga_pkg::CH_A)) begin
                    gga_state.locked = 1'b0;
                end else if (pos >= ngga_pkg::LAT_FIRST && pos <= ngga_pkg::LAT_LAST) begin
                    rep.field_code = ngga_pkg::FC_LAT_DIGIT;
                    rep.char_index = 4'(pos - ngga_pkg::LAT_FIRST);
                end else if (pos == ngga_pkg::LAT_DIR) begin
                    rep.field_code = ngga_pkg::FC_LAT_DIR;
                end else if (pos >= ngga_pkg::LON_FIRST && pos <= ngga_pkg::LON_LAST) begin
                    rep.field_code = ngga_pkg::FC_LON_DIGIT;
                    rep.char_index = 4'(pos - ngga_pkg::LON_FIRST);
                end else if (pos == ngga_pkg::LON_DIR) begin
                    rep.field_code = ngga_pkg::FC_LON_DIR;
                end else if (pos == ngga_pkg::SAT_TENS) begin
                    // Non-digit bytes go through the same arithmetic and wrap.
                    rep.field_code      = ngga_pkg::FC_SAT_TENS;
                    gga_state.sat_count = 8'((rx - ngga_pkg::CH_ZERO) * 8'd10);
                end else if (pos == ngga_pkg::SAT_UNITS) begin
                    rep.field_code      = ngga_pkg::FC_SAT_UNITS;
                    gga_state.sat_count = gga_state.sat_count + (rx - ngga_pkg::CH_ZERO);
                    gga_state.fix_valid = 1'b1;
                end
            end
        end
        rep.satellite_count = gga_state.sat_count;
        rep.fix_valid       = gga_state.fix_valid;
        rep.in_sentence     = gga_state.locked;
        return rep;
    endfunction

    // Sentence content: mostly digits, some separators, and now and then any
    // byte at all except the start character.
    function automatic logic [7:0] gga_random_char();
        int unsigned pick;
        logic [7:0]  ch;
        pick = $urandom_range(99);
        if (pick < 70) begin
            ch = ngga_pkg::CH_ZERO + 8'($urandom_range(9));
        end else if (pick < 85) begin
            ch = ($urandom_range(1) == 0) ? "," : ".";
        end else begin
            do ch = 8'($urandom); while (ch == ngga_pkg::CH_DOLLAR);
        end
        return ch;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Offers one byte and waits for the transfer. The valid line is lowered
    // only for idle cycles, so back-to-back bytes keep it high without a
    // second assignment in the same time step. The expectation is queued at
    // the edge where the transfer happens.
    task automatic send_byte(input logic [7:0] rx, input logic [1:0] flags,
                             input bit use_literal,
                             input ngga_pkg::parse_result_t literal);
        ngga_pkg::parse_result_t rep;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= flags;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
        if (flags != FLAG_NONE) begin
            error_bytes++;
        end else if (rx == ngga_pkg::CH_DOLLAR || gga_state.locked) begin
            parsed_bytes++;
        end
        rep = gga_predict(rx, flags);
        gga_reports_due.push_back(use_literal ? literal : rep);
    endtask

    // One sentence with a valid GGA header and random content, mostly long enough
    // to reach the satellite digits and sometimes long enough to saturate the
    // position. With break_header set, one of the header letters is spoiled.
    // Dropped bytes with error flags are sprinkled in between.
    task automatic send_sentence(input bit break_header);
        int unsigned len;
        int unsigned bad_pos;
        logic [7:0]  ch;
        len     = ($urandom_range(9) == 0) ? $urandom_range(55, 75) : $urandom_range(44, 50);
        bad_pos = $urandom_range(ngga_pkg::POS_HDR_G0, ngga_pkg::POS_HDR_A);
        for (int pos = 0; pos <= len; pos++) begin
            if ($urandom_range(99) < 3) begin
                send_byte(8'($urandom), 2'($urandom_range(1, 3)), 1'b0, '0);
            end
            case (pos)
                0: ch = ngga_pkg::CH_DOLLAR;
                ngga_pkg::POS_HDR_G0, ngga_pkg::POS_HDR_G1: ch = ngga_pkg::CH_G;
                ngga_pkg::POS_HDR_A: ch = ngga_pkg::CH_A;
                default: ch = gga_random_char();
            endcase
            if (break_header && pos == bad_pos) begin
                ch = ch ^ 8'($urandom_range(1, 255));
            end
            send_byte(ch, FLAG_NONE, 1'b0, '0);
        end
    endtask

    // Lowers valid and waits until every owed report has come out.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (gga_reports_due.size() != 0);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side: checks each transfer against the oldest owed report and
    // decides the ready line for the next cycle. A pending hold-off request
    // turns into a long stretch of ready low, counted here.
    initial begin
        int unsigned             holds_served;
        int unsigned             hold_left;
        ngga_pkg::parse_result_t got;
        ngga_pkg::parse_result_t want;
        holds_served = 0;
        hold_left    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got.field_code      = m_axis_tuser;
                got.char_index      = m_axis_tdata[3:0];
                got.char_value      = m_axis_tdata[11:4];
                got.satellite_count = m_axis_tdata[19:12];
                got.fix_valid       = m_axis_tdata[20];
                got.in_sentence     = m_axis_tdata[21];
                reports_seen++;
                code_seen[got.field_code]++;
                if (gga_reports_due.size() == 0) begin
                    $error("result transfer with no byte pending: tuser %0d, tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = gga_reports_due.pop_front();
                    compare_field("field_code", want.field_code, got.field_code);
                    compare_field("char_index", want.char_index, got.char_index);
                    compare_field("char_value", want.char_value, got.char_value);
                    compare_field("satellite_count", want.satellite_count,
                                  got.satellite_count);
                    compare_field("fix_valid", want.fix_valid, got.fix_valid);
                    compare_field("in_sentence", want.in_sentence, got.in_sentence);
                end
            end
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (!aresetn) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus: reset, the directed table, then random sentences in phases
    // of different idling until enough bytes have been sent.
    initial begin
        ngga_pkg::parse_result_t literal;
        int unsigned             kind;
        aresetn        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= FLAG_NONE;
        gga_state      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        mismatches     = 0;
        parsed_bytes   = 0;
        bytes_sent     = 0;
        error_bytes    = 0;
        sentences      = 0;
        header_breaks  = 0;
        reports_seen   = 0;
        foreach (code_seen[i]) code_seen[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            literal.field_code      = directed_rows[i].code;
            literal.char_index      = directed_rows[i].index;
            literal.char_value      = directed_rows[i].rx;
            literal.satellite_count = directed_rows[i].sats;
            literal.fix_valid       = directed_rows[i].fix;
            literal.in_sentence     = directed_rows[i].locked;
            repeat (directed_rows[i].repeats) begin
                send_byte(directed_rows[i].rx, directed_rows[i].flags,
                          directed_rows[i].has_literal, literal);
            end
        end
        parsed_bytes = 0;

        while (bytes_sent < ITEM_TARGET) begin
            // Every twelve sentences the sender stops until all reports are
            // in, then the idling mix changes: none, sender mostly idle,
            // receiver mostly stalled, both idling now and then.
            if (sentences % 12 == 0) begin
                drain_reports();
                case ((sentences / 12) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                    default: begin send_idle_pct = 29; recv_stall_pct = 29; end
                endcase
            end
            // The receiver holds off for a long stretch while bytes keep
            // coming, so the output register fills and input ready drops.
            if (sentences == 5 || sentences == 70) begin
                hold_requests++;
            end
            kind = $urandom_range(99);
            if (kind < 80) begin
                send_sentence(1'b0);
            end else if (kind < 90) begin
                header_breaks++;
                send_sentence(1'b1);
            end else begin
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom), 2'($urandom), 1'b0, '0);
            end
            sentences++;
        end

        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d bytes (%0d with error flags) in %0d random runs, %0d with a bad header.",
                 bytes_sent, error_bytes, sentences, header_breaks);
        $display("Random runs had %0d bytes acted on by the parser; checked %0d reports.",
                 parsed_bytes, reports_seen);
        $display("Reports by field code 0..6: %0d %0d %0d %0d %0d %0d %0d.",
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3],
                 code_seen[4], code_seen[5], code_seen[6]);
        if (mismatches == 0) begin
            $display("nmea_gga_fixed_offset_parser_tb passed");
        end else begin
            $display("nmea_gga_fixed_offset_parser_tb failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("nmea_gga_fixed_offset_parser_tb failed");
        $finish;
    end

endmodule

[nmea_gga_fixed_offset_parser.f]
+incdir+sv
sv/ngga_pkg.sv
sv/ngga_classify.sv
sv/ngga_out_reg.sv
sv/nmea_gga_fixed_offset_parser.sv
sv/ngga_checker.sv
verif/nmea_gga_fixed_offset_parser_tb.sv
